// ----- hdl/gray_cooccurrence_histogram_macros.svh -----
// Assertion helpers for the co-occurrence histogram block
`ifndef GRAY_COOCCURRENCE_HISTOGRAM_MACROS_SVH
`define GRAY_COOCCURRENCE_HISTOGRAM_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, off during reset
`define GCH_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gch check failed");
// next-cycle implication, active through reset
`define GCH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gch check failed");
`else
`define GCH_ASSERT(label, ante, cons)
`define GCH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/gch_pkg.sv -----
package gch_pkg;

  // input word kinds (tuser)
  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } act_t;

  // commands passed from front to back
  typedef enum logic [1:0] {
    CMD_PAIR  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_kind_t;

  localparam int LEVEL_BITS    = 8;
  localparam int ADDR_BITS     = 2 * LEVEL_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 11;
  localparam int OUT_BITS      = 32;
  localparam int Q_BITS        = 63;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = 2;
  localparam int FIFO_CNT_BITS = 3;

  localparam logic [OUT_BITS-1:0] FRAC_ONE = 32'h8000_0000;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DX    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DY    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NDV   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NDE   = 3'd4;

  typedef struct packed {
    cmd_kind_t            kind;
    logic                 zero;   // read of an out-of-range entry
    logic [ADDR_BITS-1:0] addr;
  } cmd_t;

endpackage

// ----- hdl/gch_fifo.sv -----
module gch_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  gch_pkg::cmd_t                       din,
  input  logic                                pop,
  output gch_pkg::cmd_t                       dout,
  output logic [gch_pkg::FIFO_CNT_BITS-1:0]   count
);
  import gch_pkg::*;

  cmd_t                     mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wp_r, rp_r;
  logic [FIFO_CNT_BITS-1:0] cnt_r;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + FIFO_PTR_BITS'(1);
      if (pop)  rp_r <= rp_r + FIFO_PTR_BITS'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + FIFO_CNT_BITS'(1);
        2'b01:   cnt_r <= cnt_r - FIFO_CNT_BITS'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  assign dout  = mem_r[rp_r];
  assign count = cnt_r;

endmodule

// ----- hdl/gch_front.sv -----
module gch_front #(
  parameter int LEVELS     = 256,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_OFFSET = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gch_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [gch_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [23:0]                        in_tdata,
  input  logic [1:0]                         in_tuser,
  input  logic                               init_busy,
  input  logic [gch_pkg::FIFO_CNT_BITS-1:0]  fifo_count,
  output logic                               push,
  output gch_pkg::cmd_t                      cmd
);
  import gch_pkg::*;

  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int CLW    = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_OFFSET + 1);
  localparam int DDEPTH = MAX_OFFSET * (MAX_WIDTH + 1);
  localparam int DAW    = $clog2(DDEPTH);
  localparam int DW     = $clog2(DDEPTH + 1);
  localparam int OW     = WW + 7;
  localparam int EW     = CLW + 7;

  // configuration registers
  logic [CFG_DATA_BITS-1:0] width_r;
  logic signed [4:0]        dx_r, dy_r;
  logic [LEVEL_BITS-1:0]    ndv_r;
  logic                     nde_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd1;
      dx_r    <= 5'sd1;
      dy_r    <= 5'sd0;
      ndv_r   <= '0;
      nde_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH: width_r <= cfg_wdata;
        CFG_DX:    dx_r    <= $signed(cfg_wdata[4:0]);
        CFG_DY:    dy_r    <= $signed(cfg_wdata[4:0]);
        CFG_NDV:   ndv_r   <= cfg_wdata[LEVEL_BITS-1:0];
        CFG_NDE:   nde_r   <= cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  // offset geometry, derived from config and registered
  logic [WW-1:0]        wcl;
  logic [4:0]           adx, ady;
  logic signed [OW-1:0] off;
  logic signed [5:0]    sdx;
  logic                 geo_ok;

  always_comb begin
    if (width_r == '0)                 wcl = WW'(1);
    else if (int'(width_r) > MAX_WIDTH) wcl = WW'(MAX_WIDTH);
    else                               wcl = WW'(width_r);
    adx    = dx_r[4] ? 5'(-dx_r) : 5'(dx_r);
    ady    = dy_r[4] ? 5'(-dy_r) : 5'(dy_r);
    off    = dy_r * $signed({1'b0, wcl}) + dx_r;
    sdx    = (off >= 0) ? 6'(dx_r) : -6'(dx_r);
    geo_ok = (int'(adx) < int'(wcl)) && (int'(adx) <= MAX_OFFSET) &&
             (int'(ady) <= MAX_OFFSET);
  end

  logic [WW-1:0]     g_w_r;
  logic [4:0]        g_ady_r;
  logic [DW-1:0]     g_dist_r;
  logic signed [5:0] g_sdx_r;
  logic              g_ok_r, g_pos_r, g_zero_r;

  always_ff @(posedge clk) begin
    g_w_r    <= wcl;
    g_ady_r  <= ady;
    g_dist_r <= (off < 0) ? DW'(-off) : DW'(off);
    g_sdx_r  <= sdx;
    g_ok_r   <= geo_ok;
    g_pos_r  <= (off > 0);
    g_zero_r <= (off == 0);
  end

  // accept and pair check
  act_t                  act;
  logic                  accept, pair_ok;
  logic [CLW-1:0]        col_r;
  logic [RW-1:0]         row_r;
  logic signed [EW-1:0]  ecol;
  logic [DAW-1:0]        wp_r, ri;
  logic [DW:0]           ri_full;
  logic [LEVEL_BITS-1:0] pix;
  logic                  s1_valid_r, s1_pair_r, s1_zero_r, s1_pos_r;
  cmd_kind_t             s1_kind_r;
  logic [LEVEL_BITS-1:0] s1_a_r, s1_b_r;

  assign act    = act_t'(in_tuser);
  assign accept = in_tvalid && in_tready;
  assign pix    = in_tdata[7:0];

  always_comb begin
    ecol    = $signed({1'b0, col_r}) - g_sdx_r;
    pair_ok = g_ok_r && (int'(row_r) >= int'(g_ady_r)) && (ecol >= 0) &&
              (ecol < $signed({1'b0, g_w_r}));
    ri_full = (DW+1)'(wp_r) - (DW+1)'(g_dist_r) +
              (((DW+1)'(wp_r) >= (DW+1)'(g_dist_r)) ? '0 : (DW+1)'(DDEPTH));
    ri      = ri_full[DAW-1:0];
  end

  // credit: room for what stage 1 holds plus the new word
  assign in_tready = !init_busy &&
                     ((int'(fifo_count) + int'(s1_valid_r)) < FIFO_DEPTH);

  // pixel delay line
  logic [LEVEL_BITS-1:0] dline [DDEPTH];
  logic [LEVEL_BITS-1:0] dl_q_r;

  always_ff @(posedge clk) begin
    if (accept && act == ACT_PIXEL) begin
      dl_q_r    <= dline[ri];
      dline[wp_r] <= pix;
    end
  end

  // raster position and write pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      wp_r  <= '0;
    end else if (accept && act == ACT_CLEAR) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept && act == ACT_PIXEL) begin
      wp_r <= (wp_r == DAW'(DDEPTH - 1)) ? '0 : wp_r + DAW'(1);
      if (int'(col_r) + 1 >= int'(g_w_r)) begin
        col_r <= '0;
        if (int'(row_r) < MAX_OFFSET) row_r <= row_r + RW'(1);
      end else begin
        col_r <= col_r + CLW'(1);
      end
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= accept && (act == ACT_PIXEL || act == ACT_READ ||
                                         act == ACT_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pair_r <= pair_ok;
      s1_zero_r <= g_zero_r;
      s1_pos_r  <= g_pos_r;
      s1_a_r    <= (act == ACT_READ) ? in_tdata[15:8] : pix;
      s1_b_r    <= in_tdata[23:16];
      case (act)
        ACT_READ:  s1_kind_r <= CMD_READ;
        ACT_CLEAR: s1_kind_r <= CMD_CLEAR;
        default:   s1_kind_r <= CMD_PAIR;
      endcase
    end
  end

  // classify and form command
  logic [LEVEL_BITS-1:0] earlier, cen, nb;
  logic                  oor, nd;

  always_comb begin
    earlier = s1_zero_r ? s1_a_r : dl_q_r;
    if (s1_kind_r == CMD_READ) begin
      cen = s1_a_r;
      nb  = s1_b_r;
    end else if (s1_pos_r) begin
      cen = earlier;
      nb  = s1_a_r;
    end else begin
      cen = s1_a_r;
      nb  = earlier;
    end
    oor      = (int'(cen) >= LEVELS) || (int'(nb) >= LEVELS);
    nd       = nde_r && (cen == ndv_r || nb == ndv_r);
    cmd.kind = s1_kind_r;
    cmd.zero = oor;
    cmd.addr = ADDR_BITS'(int'(cen) * LEVELS + int'(nb));
    push     = s1_valid_r && (s1_kind_r != CMD_PAIR || (s1_pair_r && !oor && !nd));
  end

endmodule

// ----- hdl/gch_back.sv -----
module gch_back #(
  parameter int LEVELS     = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gch_pkg::cmd_t                     fifo_dout,
  input  logic [gch_pkg::FIFO_CNT_BITS-1:0] fifo_count,
  output logic                              pop,
  output logic                              init_busy,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [95:0]                       out_tdata
);
  import gch_pkg::*;

  localparam int CDEPTH = LEVELS * LEVELS;
  localparam int AW     = $clog2(CDEPTH);
  localparam int CW     = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

  typedef enum logic [3:0] {
    ST_CLR  = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                state_r;
  logic [COUNT_BITS-1:0] cmem [CDEPTH];
  logic [COUNT_BITS-1:0] rdata_r, lw_data_r, cur, inc, wd;
  logic                  r_valid_r, r_zero_r, lw_valid_r, init_r, we;
  cmd_kind_t             r_kind_r;
  logic [AW-1:0]         r_addr_r, lw_addr_r, sweep_r, wa, head_addr;
  logic [OUT_BITS-1:0]   total_r, rem_r, cnt_r, cur32;
  logic [CW-1:0]         cur_ext;
  logic [Q_BITS-1:0]     num_r, q_r;
  logic [5:0]            step_r;
  logic [OUT_BITS:0]     trial, diff;
  logic                  ge;
  logic                  out_valid_r;
  logic [OUT_BITS-1:0]   out_count_r, out_frac_r, out_total_r;

  assign head_addr = fifo_dout.addr[AW-1:0];
  assign pop       = (state_r == ST_RUN) && (fifo_count != '0) &&
                     !(r_valid_r && r_kind_r != CMD_PAIR);
  assign init_busy = init_r;

  // read-modify-write with forwarding of the previous write
  always_comb begin
    cur     = (lw_valid_r && lw_addr_r == r_addr_r) ? lw_data_r : rdata_r;
    inc     = (cur == '1) ? cur : cur + COUNT_BITS'(1);
    cur_ext = CW'(cur);
    cur32   = (cur_ext > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : cur_ext[OUT_BITS-1:0];
    we      = 1'b0;
    wa      = r_addr_r;
    wd      = inc;
    if (state_r == ST_CLR) begin
      we = 1'b1;
      wa = sweep_r;
      wd = '0;
    end else if (r_valid_r && r_kind_r == CMD_PAIR) begin
      we = 1'b1;
    end
  end

  // count store
  always_ff @(posedge clk) begin
    if (we)  cmem[wa] <= wd;
    if (pop) rdata_r  <= cmem[head_addr];
  end

  // restoring divider step
  always_comb begin
    trial = {rem_r, num_r[Q_BITS-1]};
    diff  = trial - {1'b0, total_r};
    ge    = (trial >= {1'b0, total_r});
  end

  // command stage
  always_ff @(posedge clk) begin
    if (pop) begin
      r_kind_r <= fifo_dout.kind;
      r_zero_r <= fifo_dout.zero;
      r_addr_r <= head_addr;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      sweep_r     <= '0;
      init_r      <= 1'b1;
      r_valid_r   <= 1'b0;
      lw_valid_r  <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      r_valid_r <= pop;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLR: begin
          sweep_r    <= sweep_r + AW'(1);
          lw_valid_r <= 1'b0;
          if (sweep_r == AW'(CDEPTH - 1)) begin
            state_r <= ST_RUN;
            init_r  <= 1'b0;
          end
        end
        ST_RUN: begin
          if (r_valid_r) begin
            unique case (r_kind_r)
              CMD_PAIR: begin
                lw_valid_r <= 1'b1;
                lw_addr_r  <= r_addr_r;
                lw_data_r  <= inc;
                if (total_r != '1) total_r <= total_r + OUT_BITS'(1);
              end
              CMD_READ: begin
                cnt_r   <= r_zero_r ? '0 : cur32;
                num_r   <= {(r_zero_r ? '0 : cur32), 31'b0};
                rem_r   <= '0;
                step_r  <= '0;
                state_r <= ST_DIV;
              end
              CMD_CLEAR: begin
                sweep_r <= '0;
                total_r <= '0;
                state_r <= ST_CLR;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          rem_r  <= ge ? diff[OUT_BITS-1:0] : trial[OUT_BITS-1:0];
          q_r    <= {q_r[Q_BITS-2:0], ge};
          num_r  <= num_r << 1;
          step_r <= step_r + 6'd1;
          if (step_r == 6'(Q_BITS - 1)) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_count_r <= cnt_r;
            out_total_r <= total_r;
            if (total_r == '0)                  out_frac_r <= '0;
            else if (q_r > Q_BITS'(FRAC_ONE))   out_frac_r <= FRAC_ONE;
            else                                out_frac_r <= q_r[OUT_BITS-1:0];
            state_r <= ST_RUN;
          end
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_frac_r, out_count_r};

endmodule

// ----- hdl/gray_cooccurrence_histogram.sv -----
// Pixels: one per cycle while in_tready is high; a pair passes the stage 1 register, the
// command queue and the command stage to reach the count store. Reads: out_tvalid rises
// after the 63-step bit-serial divider and its done state; one read is in flight at a time
// while pixels keep queuing behind it. Reset (synchronous, active low) starts a clearing
// pass over all LEVELS*LEVELS entries with in_tready low; a clear word runs the same pass,
// input stalls once the four-entry queue fills. Config writes are taken at any time.
`include "gray_cooccurrence_histogram_macros.svh"
module gray_cooccurrence_histogram #(
  parameter int LEVELS     = 256,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_OFFSET = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_value, entry_centre, entry_neighbour
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata   // entry_count, entry_fraction, pair_total
);
  import gch_pkg::*;

  logic                     push, pop, init_busy;
  cmd_t                     cmd, head;
  logic [FIFO_CNT_BITS-1:0] fifo_count;

  gch_front #(
    .LEVELS(LEVELS), .MAX_WIDTH(MAX_WIDTH), .MAX_OFFSET(MAX_OFFSET)
  ) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .init_busy, .fifo_count, .push, .cmd
  );

  gch_fifo u_fifo (
    .clk, .rst_n, .push, .din(cmd), .pop, .dout(head), .count(fifo_count)
  );

  gch_back #(
    .LEVELS(LEVELS), .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk, .rst_n, .fifo_dout(head), .fifo_count, .pop, .init_busy,
    .out_tvalid, .out_tready, .out_tdata
  );

  // checks
  `GCH_ASSERT(a_count_le_total, out_tvalid, out_tdata[31:0] <= out_tdata[95:64])
  `GCH_ASSERT(a_frac_zero, out_tvalid && out_tdata[95:64] == 32'd0, out_tdata[63:32] == 32'd0)
  `GCH_ASSERT_NEXT(a_reset_blocks_input, !rst_n, !in_tready)

endmodule
